/* sv/bsc_pkg.sv */
// Shared types, constants and helpers for the barometric compensation core.
package bsc_pkg;

    localparam int CfgWidth  = 48;
    localparam int CfgIdxW   = 2;
    localparam int RawWidth  = 20;
    localparam int TempWidth = 15;
    localparam int PresWidth = 17;
    localparam int DivWidth  = 32;

    localparam logic [CfgIdxW-1:0] REG_TEMP_CAL = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRES_A   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRES_B   = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRES_C   = 2'd3;

    localparam logic signed [31:0] TEMP_MIN = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX = 32'sd8500;
    localparam logic [31:0]        PRES_MAX = 32'd131071;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    // Sideband that rides alongside the divider.
    typedef struct packed {
        logic [TempWidth-1:0] temp;
        logic                 dbl;
        logic                 zero;
    } side_t;

    function automatic logic signed [31:0] sx16(input logic signed [15:0] x);
        sx16 = {{16{x[15]}}, x};
    endfunction

    function automatic logic signed [31:0] zx16(input logic [15:0] x);
        zx16 = {16'b0, x};
    endfunction

endpackage

/* sv/bsc_front.sv */
// Compensation front end: temperature and divisor/dividend stages.
module bsc_front
    import bsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [RawWidth-1:0] raw_t,
    input  logic [RawWidth-1:0] raw_p,
    input  cal_t                cal,
    output logic                out_vld,
    output logic [DivWidth-1:0] out_num,
    output logic [DivWidth-1:0] out_div,
    output side_t               out_side
);

    logic [6:0] vld_reg;

    // stage 1
    logic signed [31:0] x1, dv, s1_m1_next, s1_dd_next;
    logic signed [31:0] s1_m1_reg, s1_dd_reg;
    logic [RawWidth-1:0] s1_p_reg;
    // stage 2
    logic signed [31:0] s2_tf_next, s2_tf_reg;
    logic [RawWidth-1:0] s2_p_reg;
    // stage 3
    logic signed [31:0] tmul, tt, pa, qa;
    logic [TempWidth-1:0] s3_t_next, s3_t_reg;
    logic signed [31:0] s3_pa_reg, s3_sq_reg, s3_m5_reg, s3_sq_next, s3_m5_next;
    logic [RawWidth-1:0] s3_p_reg;
    // stage 4
    logic signed [31:0] s4_b6_next, s4_mp3_next, s4_mp2_next;
    logic signed [31:0] s4_b6_reg, s4_mp3_reg, s4_mp2_reg, s4_m5_reg;
    logic [TempWidth-1:0] s4_t_reg;
    logic [RawWidth-1:0] s4_p_reg;
    // stage 5
    logic signed [31:0] s5_b_next, s5_s_next, aa, bsum;
    logic signed [31:0] s5_b_reg, s5_s_reg;
    logic [TempWidth-1:0] s5_t_reg;
    logic [RawWidth-1:0] s5_p_reg;
    // stage 6
    logic signed [31:0] s6_a_next, amul;
    logic [31:0] s6_p_next, s6_p_reg, bsh;
    logic signed [31:0] s6_a_reg;
    logic [TempWidth-1:0] s6_t_reg;
    // stage 7
    logic [31:0] p3125;
    logic [DivWidth-1:0] s7_num_reg, s7_div_reg;
    side_t s7_side_reg;

    always_comb begin
        x1 = {15'b0, raw_t[19:3]} - (zx16(cal.t1) <<< 1);
        s1_m1_next = x1 * sx16(cal.t2);
        dv = {16'b0, raw_t[19:4]} - zx16(cal.t1);
        s1_dd_next = dv * dv;

        s2_tf_next = (s1_m1_reg >>> 11)
                   + (((s1_dd_reg >>> 12) * sx16(cal.t3)) >>> 14);

        tmul = s2_tf_reg * 32'sd5 + 32'sd128;
        tt = tmul >>> 8;
        if (tt < TEMP_MIN)      s3_t_next = TEMP_MIN[TempWidth-1:0];
        else if (tt > TEMP_MAX) s3_t_next = TEMP_MAX[TempWidth-1:0];
        else                    s3_t_next = tt[TempWidth-1:0];
        pa = (s2_tf_reg >>> 1) - 32'sd64000;
        qa = pa >>> 2;
        s3_sq_next = qa * qa;
        s3_m5_next = pa * sx16(cal.p5);

        s4_b6_next  = (s3_sq_reg >>> 11) * sx16(cal.p6);
        s4_mp3_next = sx16(cal.p3) * (s3_sq_reg >>> 13);
        s4_mp2_next = sx16(cal.p2) * s3_pa_reg;

        bsum = s4_b6_reg + (s4_m5_reg <<< 1);
        s5_b_next = (bsum >>> 2) + (sx16(cal.p4) <<< 16);
        aa = ((s4_mp3_reg >>> 3) + (s4_mp2_reg >>> 1)) >>> 18;
        s5_s_next = 32'sd32768 + aa;

        amul = s5_s_reg * zx16(cal.p1);
        s6_a_next = amul >>> 15;
        bsh = 32'(s5_b_reg >>> 12);
        s6_p_next = (32'd1048576 - {12'b0, s5_p_reg}) - bsh;

        p3125 = s6_p_reg * 32'd3125;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_m1_reg <= s1_m1_next;
            s1_dd_reg <= s1_dd_next;
            s1_p_reg  <= raw_p;

            s2_tf_reg <= s2_tf_next;
            s2_p_reg  <= s1_p_reg;

            s3_t_reg  <= s3_t_next;
            s3_pa_reg <= pa;
            s3_sq_reg <= s3_sq_next;
            s3_m5_reg <= s3_m5_next;
            s3_p_reg  <= s2_p_reg;

            s4_b6_reg  <= s4_b6_next;
            s4_mp3_reg <= s4_mp3_next;
            s4_mp2_reg <= s4_mp2_next;
            s4_m5_reg  <= s3_m5_reg;
            s4_t_reg   <= s3_t_reg;
            s4_p_reg   <= s3_p_reg;

            s5_b_reg <= s5_b_next;
            s5_s_reg <= s5_s_next;
            s5_t_reg <= s4_t_reg;
            s5_p_reg <= s4_p_reg;

            s6_a_reg <= s6_a_next;
            s6_p_reg <= s6_p_next;
            s6_t_reg <= s5_t_reg;

            // quotient doubled afterwards when the dividend top bit is set
            s7_num_reg       <= p3125[31] ? p3125 : {p3125[30:0], 1'b0};
            s7_div_reg       <= s6_a_reg;
            s7_side_reg.dbl  <= p3125[31];
            s7_side_reg.zero <= (s6_a_reg == 32'sd0);
            s7_side_reg.temp <= s6_t_reg;
        end
    end

    assign out_vld  = vld_reg[6];
    assign out_num  = s7_num_reg;
    assign out_div  = s7_div_reg;
    assign out_side = s7_side_reg;

endmodule

/* sv/bsc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
module bsc_divider
    import bsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [DivWidth-1:0] in_num,
    input  logic [DivWidth-1:0] in_div,
    input  side_t               in_side,
    output logic                out_vld,
    output logic [DivWidth-1:0] out_quo,
    output side_t               out_side
);

    logic [DivWidth-1:0] rem_reg [1:DivWidth];
    logic [DivWidth-1:0] nq_reg  [1:DivWidth];
    logic [DivWidth-1:0] dv_reg  [1:DivWidth];
    side_t               side_reg[1:DivWidth];
    logic [DivWidth:1]   vld_reg;

    for (genvar k = 0; k < DivWidth; k++) begin : g_stage
        logic [DivWidth-1:0] rem_c, nq_c, dv_c;
        side_t               side_c;
        logic                vld_c, ge;
        logic [DivWidth:0]   rs, rn;

        if (k == 0) begin : g_first
            assign rem_c  = '0;
            assign nq_c   = in_num;
            assign dv_c   = in_div;
            assign side_c = in_side;
            assign vld_c  = in_vld;
        end else begin : g_rest
            assign rem_c  = rem_reg[k];
            assign nq_c   = nq_reg[k];
            assign dv_c   = dv_reg[k];
            assign side_c = side_reg[k];
            assign vld_c  = vld_reg[k];
        end

        always_comb begin
            rs = {rem_c, nq_c[DivWidth-1]};
            ge = (rs >= {1'b0, dv_c});
            rn = ge ? (rs - {1'b0, dv_c}) : rs;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_c;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rn[DivWidth-1:0];
                nq_reg[k+1]   <= {nq_c[DivWidth-2:0], ge};
                dv_reg[k+1]   <= dv_c;
                side_reg[k+1] <= side_c;
            end
        end
    end

    assign out_vld  = vld_reg[DivWidth];
    assign out_quo  = nq_reg[DivWidth];
    assign out_side = side_reg[DivWidth];

endmodule

/* sv/bsc_back.sv */
// Pressure refinement after the division, with saturation and result register.
module bsc_back
    import bsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [DivWidth-1:0]   in_quo,
    input  side_t                 in_side,
    input  cal_t                  cal,
    output logic                  out_vld,
    output logic [TempWidth-1:0]  out_temp,
    output logic [PresWidth-1:0]  out_pres,
    output logic                  out_good
);

    logic [2:0] vld_reg;

    logic [31:0] p, ps, psq;
    logic signed [31:0] sa_sq_next, sa_m8_next;
    logic [31:0] sa_p_reg;
    logic signed [31:0] sa_sq_reg, sa_m8_reg;
    side_t sa_side_reg;

    logic signed [31:0] sb_a9_next, sb_a9_reg, sb_m8_reg;
    logic [31:0] sb_p_reg;
    side_t sb_side_reg;

    logic signed [31:0] dsum, dd;
    logic [31:0] pf;
    logic [PresWidth-1:0] pres_next;
    logic [TempWidth-1:0] temp_reg;
    logic [PresWidth-1:0] pres_reg;
    logic                 good_reg;

    always_comb begin
        p = in_side.dbl ? {in_quo[30:0], 1'b0} : in_quo;
        ps = {3'b0, p[31:3]};
        psq = ps * ps;
        sa_sq_next = {13'b0, psq[31:13]};
        sa_m8_next = $signed({2'b0, p[31:2]}) * sx16(cal.p8);

        sb_a9_next = (sx16(cal.p9) * sa_sq_reg) >>> 12;

        dsum = sb_a9_reg + (sb_m8_reg >>> 13) + sx16(cal.p7);
        dd = dsum >>> 4;
        pf = sb_p_reg + 32'(dd);
        if (sb_side_reg.zero)  pres_next = '0;
        else if (pf > PRES_MAX) pres_next = PRES_MAX[PresWidth-1:0];
        else                    pres_next = pf[PresWidth-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_p_reg    <= p;
            sa_sq_reg   <= sa_sq_next;
            sa_m8_reg   <= sa_m8_next;
            sa_side_reg <= in_side;

            sb_a9_reg   <= sb_a9_next;
            sb_m8_reg   <= sa_m8_reg;
            sb_p_reg    <= sa_p_reg;
            sb_side_reg <= sa_side_reg;

            temp_reg <= sb_side_reg.temp;
            pres_reg <= pres_next;
            good_reg <= !sb_side_reg.zero;
        end
    end

    assign out_vld  = vld_reg[2];
    assign out_temp = temp_reg;
    assign out_pres = pres_reg;
    assign out_good = good_reg;

endmodule

/* sv/barometric_sensor_compensation_core.sv */
// Top level of the barometric compensation core: config registers and pipeline.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_raw_temperature, s_raw_pressure
//  m_        out        m_valid/m_ready    m_temperature_centi, m_pressure_pa, m_valid_res
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (48-bit)
//
// One request per cycle sustained while no m_ready stall holds the pipeline; 7 front
// stages, 32 divider stages with one quotient bit each, 3 back stages ending in the
// result register. Every stage moves in each cycle that the pipeline is not stalled.
// Reset (aresetn low, synchronous) clears all stage valid bits and calibration.
// A stall on m_ready freezes the whole pipeline; s_ready stays high while the
// result register is empty or being drained, so nothing is lost or repeated.
module barometric_sensor_compensation_core
    import bsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [RawWidth-1:0]  s_raw_temperature,
    input  logic [RawWidth-1:0]  s_raw_pressure,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [TempWidth-1:0] m_temperature_centi,
    output logic [PresWidth-1:0] m_pressure_pa,
    output logic                 m_valid_res,

    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgWidth-1:0]  cfg_wdata
);

    logic [CfgWidth-1:0] temp_cal_reg, pres_a_reg, pres_b_reg, pres_c_reg;
    cal_t cal;
    logic en;

    logic                f_vld;
    logic [DivWidth-1:0] f_num, f_div;
    side_t               f_side;
    logic                d_vld;
    logic [DivWidth-1:0] d_quo;
    side_t               d_side;
    logic [TempWidth-1:0] temp_out;

    // calibration registers; write only while idle (the block itself does not enforce it)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg <= '0;
            pres_a_reg   <= '0;
            pres_b_reg   <= '0;
            pres_c_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TEMP_CAL: temp_cal_reg <= cfg_wdata;
                REG_PRES_A:   pres_a_reg   <= cfg_wdata;
                REG_PRES_B:   pres_b_reg   <= cfg_wdata;
                REG_PRES_C:   pres_c_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // unpack the twelve calibration words
    assign cal.t1 = temp_cal_reg[15:0];
    assign cal.t2 = temp_cal_reg[31:16];
    assign cal.t3 = temp_cal_reg[47:32];
    assign cal.p1 = pres_a_reg[15:0];
    assign cal.p2 = pres_a_reg[31:16];
    assign cal.p3 = pres_a_reg[47:32];
    assign cal.p4 = pres_b_reg[15:0];
    assign cal.p5 = pres_b_reg[31:16];
    assign cal.p6 = pres_b_reg[47:32];
    assign cal.p7 = pres_c_reg[15:0];
    assign cal.p8 = pres_c_reg[31:16];
    assign cal.p9 = pres_c_reg[47:32];

    // global advance: result register empty or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    bsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .raw_t    (s_raw_temperature),
        .raw_p    (s_raw_pressure),
        .cal      (cal),
        .out_vld  (f_vld),
        .out_num  (f_num),
        .out_div  (f_div),
        .out_side (f_side)
    );

    bsc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f_vld),
        .in_num   (f_num),
        .in_div   (f_div),
        .in_side  (f_side),
        .out_vld  (d_vld),
        .out_quo  (d_quo),
        .out_side (d_side)
    );

    bsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (d_vld),
        .in_quo   (d_quo),
        .in_side  (d_side),
        .cal      (cal),
        .out_vld  (m_valid),
        .out_temp (temp_out),
        .out_pres (m_pressure_pa),
        .out_good (m_valid_res)
    );

    assign m_temperature_centi = $signed(temp_out);

endmodule

/* verif/tb.sv */
// Testbench for the barometric compensation core: directed and random checks.
module tb;
    import bsc_pkg::*;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [RawWidth-1:0]         s_raw_temperature = '0;
    logic [RawWidth-1:0]         s_raw_pressure = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [TempWidth-1:0] m_temperature_centi;
    logic [PresWidth-1:0]        m_pressure_pa;
    logic                        m_valid_res;
    logic                        cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]          cfg_index = REG_TEMP_CAL;
    logic [CfgWidth-1:0]         cfg_wdata = '0;

    localparam int Latency = 42;
    localparam int Watchdog = 20000;

    typedef struct packed {
        logic [TempWidth-1:0] temp;
        logic [PresWidth-1:0] pres;
        logic                 ok;
    } reading_t;

    // Scoreboard: holds the calibration copy and the queue of predicted readings.
    class comp_scoreboard;
        logic [CfgWidth-1:0] cal [4];
        reading_t            pending [$];
        int                  errors;
        int                  checked;
        int                  invalid_seen;

        function void write_cal(logic [CfgIdxW-1:0] idx, logic [CfgWidth-1:0] v);
            cal[idx] = v;
        endfunction

        function automatic logic signed [31:0] w16(int r, int pos, bit sgn);
            logic [15:0] f;
            f = cal[r][pos +: 16];
            return sgn ? {{16{f[15]}}, f} : {16'b0, f};
        endfunction

        // Fixed-point compensation, 32-bit wrapping, arithmetic shifts on signed terms.
        function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp);
            logic signed [31:0] adt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [31:0] a, b, d, tf, t, sq;
            logic [31:0] p, dv;
            logic [63:0] wide;
            reading_t r;
            adt = {12'b0, rt};
            t1 = w16(0, 0, 0);  t2 = w16(0, 16, 1); t3 = w16(0, 32, 1);
            p1 = w16(1, 0, 0);  p2 = w16(1, 16, 1); p3 = w16(1, 32, 1);
            p4 = w16(2, 0, 1);  p5 = w16(2, 16, 1); p6 = w16(2, 32, 1);
            p7 = w16(3, 0, 1);  p8 = w16(3, 16, 1); p9 = w16(3, 32, 1);
            a = ((adt >>> 3) - (t1 <<< 1)) * t2;
            a = a >>> 11;
            d = (adt >>> 4) - t1;
            b = (d * d) >>> 12;
            b = (b * t3) >>> 14;
            tf = a + b;
            t = (tf * 5 + 128) >>> 8;
            if (t < TEMP_MIN) t = TEMP_MIN;
            if (t > TEMP_MAX) t = TEMP_MAX;
            r.temp = t[TempWidth-1:0];
            a = (tf >>> 1) - 32'sd64000;
            sq = (a >>> 2) * (a >>> 2);
            b = (sq >>> 11) * p6;
            b = b + ((a * p5) <<< 1);
            b = (b >>> 2) + (p4 <<< 16);
            a = (((p3 * (sq >>> 13)) >>> 3) + ((p2 * a) >>> 1)) >>> 18;
            a = ((32'sd32768 + a) * p1) >>> 15;
            if (a == 0) begin
                r.ok = 1'b0;
                r.pres = '0;
                return r;
            end
            r.ok = 1'b1;
            dv = a;
            p = 32'd1048576 - {12'b0, rp} - 32'(b >>> 12);
            p = p * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / dv;
            else p = (p / dv) * 2;
            wide = {32'b0, p >> 3} * {32'b0, p >> 3};
            sq = wide[31:0] >> 13;
            a = (p9 * sq) >>> 12;
            b = ($signed(p >> 2) * p8) >>> 13;
            d = (a + b + p7) >>> 4;
            p = p + d;
            if (p > PRES_MAX) p = PRES_MAX;
            r.pres = p[PresWidth-1:0];
            return r;
        endfunction

        function void note_request(logic [19:0] rt, logic [19:0] rp);
            pending.push_back(compensate(rt, rp));
        endfunction

        function void check_result(logic [TempWidth-1:0] t, logic [PresWidth-1:0] p,
                                   logic ok);
            reading_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (!ok) invalid_seen++;
            if (t !== e.temp) begin
                $error("temperature_centi expected %0d got %0d",
                       $signed(e.temp), $signed(t));
                errors++;
            end
            if (p !== e.pres) begin
                $error("pressure_pa expected %0d got %0d", e.pres, p);
                errors++;
            end
            if (ok !== e.ok) begin
                $error("valid_res expected %0d got %0d", e.ok, ok);
                errors++;
            end
        endfunction
    endclass

    comp_scoreboard sb = new();

    int send_idle;   // percent of cycles the sender holds back
    int recv_stall;  // percent of cycles the receiver stalls
    int quiet_cycles;

    barometric_sensor_compensation_core i_dut (.*);

    always #1 aclk = ~aclk;

    // Receiver: random stall, check on every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_temperature_centi, m_pressure_pa, m_valid_res);
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: counts cycles with no request or result moving.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= Watchdog) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgWidth-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.write_cal(idx, v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Present one request, holding it until it is accepted.
    // Valid stays up between back-to-back requests; it drops only for idle gaps.
    task automatic send_request(logic [19:0] rt, logic [19:0] rp);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_raw_temperature <= rt;
        s_raw_pressure <= rp;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(rt, rp);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
    endtask

    // Plausible calibration: typical signs and magnitudes, random spread.
    task automatic load_typical_cal();
        logic [15:0] w [12];
        w[0] = 16'd27000 + 16'($urandom_range(2000));          // T1
        w[1] = 16'd26000 + 16'($urandom_range(1500));          // T2
        w[2] = 16'($urandom_range(2000)) - 16'd1000;           // T3
        w[3] = 16'd35000 + 16'($urandom_range(4000));          // P1
        w[4] = -16'sd10700 + 16'($urandom_range(300));         // P2
        w[5] = 16'd3000 + 16'($urandom_range(400));            // P3
        w[6] = 16'd6000 + 16'($urandom_range(2000));           // P4
        w[7] = 16'($urandom_range(400)) - 16'd200;             // P5
        w[8] = -16'sd7;                                        // P6
        w[9] = 16'd15500;                                      // P7
        w[10] = -16'sd14600 + 16'($urandom_range(200));        // P8
        w[11] = 16'd6000;                                      // P9
        write_reg(REG_TEMP_CAL, {w[2], w[1], w[0]});
        write_reg(REG_PRES_A, {w[5], w[4], w[3]});
        write_reg(REG_PRES_B, {w[8], w[7], w[6]});
        write_reg(REG_PRES_C, {w[11], w[10], w[9]});
    endtask

    task automatic load_random_cal();
        write_reg(REG_TEMP_CAL, 48'({$urandom, $urandom}));
        write_reg(REG_PRES_A, 48'({$urandom, $urandom}));
        write_reg(REG_PRES_B, 48'({$urandom, $urandom}));
        write_reg(REG_PRES_C, 48'({$urandom, $urandom}));
    endtask

    task automatic random_burst(int n);
        logic [19:0] rt, rp;
        for (int i = 0; i < n; i++) begin
            // mostly realistic readings, some full-range values
            if ($urandom_range(3) != 0) begin
                rt = 20'd480000 + 20'($urandom_range(120000));
                rp = 20'd250000 + 20'($urandom_range(250000));
            end else begin
                rt = 20'($urandom);
                rp = 20'($urandom);
            end
            send_request(rt, rp);
        end
    endtask

    initial begin
        send_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 4; i++) sb.cal[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset calibration: P1 is zero, so every pressure is invalid.
        send_request('0, '0);
        send_request('1, '1);
        drain();

        // Typical calibration, field extremes.
        load_typical_cal();
        send_request('0, '0);
        send_request('1, '1);
        send_request('0, '1);
        send_request('1, '0);
        send_request(20'd519888, 20'd415148);
        send_request(20'h55555, 20'hAAAAA);
        send_request(20'hAAAAA, 20'h55555);
        drain();

        // All ones, then most-negative and most-positive words: wraps, saturation, large divisors.
        write_reg(REG_TEMP_CAL, '1);
        write_reg(REG_PRES_A, '1);
        write_reg(REG_PRES_B, '1);
        write_reg(REG_PRES_C, '1);
        send_request('0, '0);
        send_request('1, '1);
        send_request(20'd519888, 20'd0);
        drain();
        write_reg(REG_TEMP_CAL, 48'h8000_8000_FFFF);
        write_reg(REG_PRES_A, 48'h7FFF_8000_FFFF);
        write_reg(REG_PRES_B, 48'h8000_7FFF_8000);
        write_reg(REG_PRES_C, 48'h7FFF_7FFF_8000);
        send_request('0, '1);
        send_request('1, '0);
        send_request(20'd400000, 20'd300000);
        drain();

        // Random phases with varied idling and calibration.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            if (ph == 3 || ph == 6) load_random_cal();
            else load_typical_cal();
            random_burst(ph == 1 || ph == 2 ? 150 : 250);
            // sender holds off until every pending result is back
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        drain();
        $display("Covered %0d results (%0d flagged invalid) over eight idling phases",
                 sb.checked, sb.invalid_seen);
        $display("with typical, random and extreme calibration sets.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/bsc_pkg.sv
sv/bsc_front.sv
sv/bsc_divider.sv
sv/bsc_back.sv
sv/barometric_sensor_compensation_core.sv
verif/tb.sv
